// ----- rtl/sorted_list_insert_delete_macros.svh -----
// ----------------------------------------------------------------------------
// Sorted list assertion macros
// Assertion shorthands used by the sorted list checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_MACROS_SVH

// Clocked assertion that is disabled while reset is asserted.
`define SLI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication that must hold on the cycle after the trigger.
`define SLI_ASSERT_NEXT(label, trig, cons, msg) \
	`SLI_ASSERT(label, (trig) |=> (cons), msg)

// Implication that must hold in the same cycle as the trigger.
`define SLI_ASSERT_NOW(label, trig, cons, msg) \
	`SLI_ASSERT(label, (trig) |-> (cons), msg)

`endif

// ----- rtl/sli_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted list package
// Sizes, codes and transaction types shared by the sorted list modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_DELETE = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_DELETED   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		req_type_t                  req_type;
		logic signed [VALUE_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] entry_count;
	} rsp_item_t;

	// Broadcast to every cell of the row.
	typedef struct packed {
		logic                       ins;
		logic                       del;
		logic signed [VALUE_W-1:0] value;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_list_insert_delete.sv -----
// ----------------------------------------------------------------------------
// Sorted list insert and delete
// Ordered store of signed values held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_ready  sli_pkg::req_item_t
// rsp      out        rsp_valid / rsp_ready  sli_pkg::rsp_item_t
//
// All cells compare in parallel and shift in the same edge, so one
// transaction per cycle is sustained while rsp_ready stays high. The response
// appears in the output register on the next cycle.
// A stalled response holds req_ready low until it is taken.
// Reset clears the entry count; stored values are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_delete (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire sli_pkg::req_item_t  req,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output sli_pkg::rsp_item_t       rsp
);

	logic [sli_pkg::CNT_W-1:0]          count_q;
	logic                               rsp_valid_q;
	sli_pkg::rsp_item_t                 rsp_q;
	logic                               req_fire;
	logic                               full;
	logic                               found;
	sli_pkg::cell_ctrl_t                ctrl;
	sli_pkg::rsp_item_t                 rsp_next;
	logic [sli_pkg::CNT_W-1:0]          count_next;
	logic [sli_pkg::CAPACITY-1:0]       lt;
	logic [sli_pkg::CAPACITY-1:0]       hit;
	logic signed [sli_pkg::VALUE_W-1:0] cell_value [sli_pkg::CAPACITY];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign req_fire  = req_valid && req_ready;
	assign full      = (count_q == sli_pkg::CAP_CNT);
	assign found     = |hit;

	always_comb begin
		ctrl.value = req.value;
		ctrl.ins   = req_fire && (req.req_type == sli_pkg::REQ_INSERT) && !full;
		ctrl.del   = req_fire && (req.req_type == sli_pkg::REQ_DELETE) && found;
	end

	always_comb begin
		count_next = count_q;
		unique case (req.req_type)
			sli_pkg::REQ_INSERT: begin
				if (full) begin
					rsp_next.status = sli_pkg::ST_FULL;
				end else begin
					rsp_next.status = sli_pkg::ST_INSERTED;
					count_next      = count_q + sli_pkg::CNT_W'(1);
				end
			end
			sli_pkg::REQ_DELETE: begin
				if (found) begin
					rsp_next.status = sli_pkg::ST_DELETED;
					count_next      = count_q - sli_pkg::CNT_W'(1);
				end else begin
					rsp_next.status = sli_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				rsp_next.status = sli_pkg::ST_NOT_FOUND;
			end
		endcase
		rsp_next.entry_count = count_next;
	end

	for (genvar i = 0; i < sli_pkg::CAPACITY; i++) begin : g_cell
		logic                               left_lt;
		logic signed [sli_pkg::VALUE_W-1:0] left_value;
		logic signed [sli_pkg::VALUE_W-1:0] right_value;

		if (i == 0) begin : g_head
			assign left_lt    = 1'b1;
			assign left_value = req.value;
		end else begin : g_body
			assign left_lt    = lt[i-1];
			assign left_value = cell_value[i-1];
		end

		if (i == sli_pkg::CAPACITY - 1) begin : g_tail
			assign right_value = cell_value[i];
		end else begin : g_inner
			assign right_value = cell_value[i+1];
		end

		sli_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (sli_pkg::CNT_W'(i) < count_q),
			.left_lt     (left_lt),
			.left_value  (left_value),
			.right_value (right_value),
			.lt          (lt[i]),
			.hit         (hit[i]),
			.value       (cell_value[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_fire) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/sli_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted list cell
// One slot of the sorted row: compares against the request value and takes
// the request value or a neighbor's value when the row shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_cell (
	input  wire logic                                clk,
	input  wire sli_pkg::cell_ctrl_t                 ctrl,
	input  wire logic                                occupied,
	input  wire logic                                left_lt,
	input  wire logic signed [sli_pkg::VALUE_W-1:0] left_value,
	input  wire logic signed [sli_pkg::VALUE_W-1:0] right_value,
	output logic                                     lt,
	output logic                                     hit,
	output logic signed [sli_pkg::VALUE_W-1:0]      value
);

	logic signed [sli_pkg::VALUE_W-1:0] value_q;

	assign lt    = occupied && (value_q < ctrl.value);
	assign hit   = occupied && left_lt && !lt && (value_q == ctrl.value);
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt) begin
			value_q <= left_lt ? ctrl.value : left_value;
		end else if (ctrl.del && !lt) begin
			value_q <= right_value;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sli_checker.sv -----
// ----------------------------------------------------------------------------
// Sorted list checker
// Port-level assertions for the sorted list block, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_list_insert_delete_macros.svh"

module sli_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_ready,
	input wire sli_pkg::req_item_t req,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire sli_pkg::rsp_item_t rsp
);

	`SLI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled response changed")
	`SLI_ASSERT_NEXT(a_req_gives_rsp, req_valid && req_ready, rsp_valid, "accepted request gave no response")
	`SLI_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready, "request refused with no response pending")
	`SLI_ASSERT_NOW(a_count_range, rsp_valid, rsp.entry_count <= sli_pkg::CAP_CNT, "entry count beyond capacity")
	`SLI_ASSERT_NOW(a_full_count, rsp_valid && rsp.status == sli_pkg::ST_FULL, rsp.entry_count == sli_pkg::CAP_CNT, "full status with store not full")

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (.*);

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted list insert and delete testbench
// Drives insert and delete requests into the ordered store and predicts each
// response from a queue kept in ascending order. A directed sequence covers
// the empty, duplicate, extreme-value and full cases; random bursts with
// shifting insert/delete mixes then move the store between empty and full
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int RANDOM_ITEMS = 1600;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int LONG_HOLD    = 300;

	class sorted_list_scoreboard;
		logic signed [sli_pkg::VALUE_W-1:0] held_values[$];
		sli_pkg::rsp_item_t                 expected_rsp[$];
		int unsigned                        failures = 0;

		function int pending();
			return expected_rsp.size();
		endfunction

		function void note_request(sli_pkg::req_item_t r);
			logic signed [sli_pkg::VALUE_W-1:0] v;
			sli_pkg::rsp_item_t                 e;
			int                                 pos;
			v   = r.value;
			pos = 0;
			if (r.req_type == sli_pkg::REQ_INSERT) begin
				if (held_values.size() >= sli_pkg::CAPACITY) begin
					e.status = sli_pkg::ST_FULL;
				end else begin
					while (pos < held_values.size() && held_values[pos] < v)
						pos++;
					held_values.insert(pos, v);
					e.status = sli_pkg::ST_INSERTED;
				end
			end else begin
				while (pos < held_values.size() && held_values[pos] != v)
					pos++;
				if (pos >= held_values.size()) begin
					e.status = sli_pkg::ST_NOT_FOUND;
				end else begin
					held_values.delete(pos);
					e.status = sli_pkg::ST_DELETED;
				end
			end
			e.entry_count = sli_pkg::CNT_W'(held_values.size());
			expected_rsp.push_back(e);
		endfunction

		function void check_result(sli_pkg::rsp_item_t a);
			sli_pkg::rsp_item_t e;
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected response status=%0d entry_count=%0d",
					$time, a.status, a.entry_count);
				failures++;
				return;
			end
			e = expected_rsp.pop_front();
			if (a.status !== e.status) begin
				$display("%0t: status mismatch, expected %0d, actual %0d",
					$time, e.status, a.status);
				failures++;
			end
			if (a.entry_count !== e.entry_count) begin
				$display("%0t: entry_count mismatch, expected %0d, actual %0d",
					$time, e.entry_count, a.entry_count);
				failures++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	sli_pkg::req_item_t req;
	logic               rsp_valid;
	logic               rsp_ready;
	sli_pkg::rsp_item_t rsp;

	sorted_list_scoreboard sb = new();
	int unsigned           cycle_count = 0;
	bit                    rsp_hold_req = 1'b0;

	sorted_list_insert_delete dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp);
		end
	end

	function automatic sli_pkg::req_item_t req_of(sli_pkg::req_type_t t,
		logic signed [sli_pkg::VALUE_W-1:0] v);
		sli_pkg::req_item_t r;
		r.req_type = t;
		r.value    = v;
		return r;
	endfunction

	function automatic sli_pkg::req_item_t pick_request(int ins_pct);
		sli_pkg::req_item_t r;
		int                 held;
		held       = sb.held_values.size();
		r.req_type = ($urandom_range(99) < ins_pct) ? sli_pkg::REQ_INSERT
			: sli_pkg::REQ_DELETE;
		case ($urandom_range(9))
			0, 1, 2, 3: r.value = $urandom;
			4, 5, 6:    r.value = $signed($urandom_range(8)) - 4;
			7: begin
				case ($urandom_range(3))
					0: r.value = 32'sh7FFF_FFFF;
					1: r.value = 32'sh8000_0000;
					2: r.value = '0;
					default: r.value = '1;
				endcase
			end
			default: begin
				if (held > 0)
					r.value = sb.held_values[$urandom_range(held - 1)];
				else
					r.value = $urandom;
			end
		endcase
		return r;
	endfunction

	task automatic send_request(sli_pkg::req_item_t item);
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		int mode;
		int seg;
		while (!arst_n) @(posedge clk);
		forever begin
			if (rsp_hold_req) begin
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_hold_req = 1'b0;
			end else begin
				mode = $urandom_range(3);
				seg  = $urandom_range(1, 64);
				repeat (seg) begin
					case (mode)
						0: rsp_ready <= 1'b1;
						1: rsp_ready <= ($urandom_range(3) != 0);
						2: rsp_ready <= ($urandom_range(3) == 0);
						default: rsp_ready <= ~rsp_ready;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		int pct_choice[4];
		int sent;
		int next_drain;
		int burst_len;
		int ins_pct;
		int gap;
		bit hold_done;

		pct_choice = '{15, 50, 85, 100};
		clk        = 1'b0;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		rsp_ready  = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(req_of(sli_pkg::REQ_DELETE, 32'sd0));
		send_request(req_of(sli_pkg::REQ_INSERT, 32'sh7FFF_FFFF));
		send_request(req_of(sli_pkg::REQ_INSERT, 32'sh8000_0000));
		send_request(req_of(sli_pkg::REQ_INSERT, 32'sd0));
		send_request(req_of(sli_pkg::REQ_INSERT, -32'sd1));
		send_request(req_of(sli_pkg::REQ_INSERT, 32'sd0));
		send_request(req_of(sli_pkg::REQ_DELETE, 32'sd0));
		send_request(req_of(sli_pkg::REQ_DELETE, 32'sd12345));
		for (int i = 0; i < 12; i++)
			send_request(req_of(sli_pkg::REQ_INSERT, 32'(i * 3 - 10)));
		send_request(req_of(sli_pkg::REQ_INSERT, 32'sd7));
		send_request(req_of(sli_pkg::REQ_DELETE, 32'sh8000_0000));
		send_request(req_of(sli_pkg::REQ_DELETE, 32'sh7FFF_FFFF));
		send_request(req_of(sli_pkg::REQ_INSERT, 32'sd5));
		drain_results();

		sent       = 0;
		next_drain = 400;
		hold_done  = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			burst_len = $urandom_range(1, 32);
			ins_pct   = pct_choice[$urandom_range(3)];
			repeat (burst_len) begin
				send_request(pick_request(ins_pct));
				sent++;
			end
			if (!hold_done && sent >= 300) begin
				rsp_hold_req = 1'b1;
				hold_done    = 1'b1;
			end
			if (sent >= next_drain) begin
				drain_results();
				next_drain += 400;
			end else begin
				gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sli_pkg.sv
rtl/sli_cell.sv
rtl/sorted_list_insert_delete.sv
rtl/sli_checker.sv
test/tb_top.sv
